FILE: rtl/lbmc_pkg.sv
`default_nettype none

package lbmc_pkg;

    typedef enum logic [2:0] {
        MODE_DEMO   = 3'd0,
        MODE_ON     = 3'd1,
        MODE_OFF    = 3'd2,
        MODE_STROBE = 3'd3,
        MODE_BEACON = 3'd4
    } mode_t;

    // demo stages
    localparam logic [1:0] STAGE_ON     = 2'd0;
    localparam logic [1:0] STAGE_STROBE = 2'd1;
    localparam logic [1:0] STAGE_BEACON = 2'd2;
    localparam logic [1:0] STAGE_OFF    = 2'd3;

    // input op codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    // command characters
    localparam logic [7:0] CH_ONE = 8'h31;  // '1'
    localparam logic [7:0] CH_ZERO = 8'h30; // '0'
    localparam logic [7:0] CH_O_LC = 8'h6f;
    localparam logic [7:0] CH_O_UC = 8'h4f;
    localparam logic [7:0] CH_F_LC = 8'h66;
    localparam logic [7:0] CH_F_UC = 8'h46;
    localparam logic [7:0] CH_S_LC = 8'h73;
    localparam logic [7:0] CH_S_UC = 8'h53;
    localparam logic [7:0] CH_B_LC = 8'h62;
    localparam logic [7:0] CH_B_UC = 8'h42;
    localparam logic [7:0] CH_P_LC = 8'h70;
    localparam logic [7:0] CH_P_UC = 8'h50;
    localparam logic [7:0] CH_D_LC = 8'h64;
    localparam logic [7:0] CH_D_UC = 8'h44;
    localparam logic [7:0] CH_H_LC = 8'h68;
    localparam logic [7:0] CH_H_UC = 8'h48;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_STROBE_HALF   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BEACON_HALF   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEMO_ON       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DEMO_OFF      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DEMO_STROBE_N = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DEMO_BEACON_N = 3'd6;

    typedef struct packed {
        logic [15:0] strobe_half_ms;
        logic [15:0] beacon_half_ms;
        logic [15:0] pulse_ms;
        logic [15:0] demo_on_ms;
        logic [15:0] demo_off_ms;
        logic [7:0]  demo_strobe_cycles;
        logic [7:0]  demo_beacon_cycles;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic        laser;
        logic [15:0] phase_timer;
        logic        half_phase;
        logic [1:0]  demo_stage;
        logic [7:0]  cycle_count;
        logic        pulse_busy;
        logic [15:0] pulse_timer;
    } state_t;

    typedef struct packed {
        logic       laser_on;
        logic [2:0] mode;
        logic       unknown_cmd;
        logic       pulse_active;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/lbmc_if.sv
`default_nettype none

interface lbmc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] cmd_byte;

    modport source (output valid, output op, output cmd_byte, input ready);
    modport sink   (input valid, input op, input cmd_byte, output ready);
endinterface

interface lbmc_out_if;
    logic       valid;
    logic       ready;
    logic       laser_on;
    logic [2:0] mode;
    logic       unknown_cmd;
    logic       pulse_active;

    modport source (output valid, output laser_on, output mode, output unknown_cmd,
                    output pulse_active, input ready);
    modport sink   (input valid, input laser_on, input mode, input unknown_cmd,
                    input pulse_active, output ready);
endinterface

interface lbmc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lbmc_pkg::CFG_ADDR_W-1:0]     addr;
    logic [lbmc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lbmc_cfg_regs.sv
`default_nettype none

module lbmc_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lbmc_cfg_if.sink           cfg_ch,
    output lbmc_pkg::cfg_t     cfg
);

    lbmc_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign cfg_ch.ready = 1'b1;
    assign wr_en        = cfg_ch.valid;
    assign cfg          = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strobe_half_ms     <= 16'd50;
            cfg_reg.beacon_half_ms     <= 16'd250;
            cfg_reg.pulse_ms           <= 16'd500;
            cfg_reg.demo_on_ms         <= 16'd2000;
            cfg_reg.demo_off_ms        <= 16'd1500;
            cfg_reg.demo_strobe_cycles <= 8'd15;
            cfg_reg.demo_beacon_cycles <= 8'd3;
        end
        else if (wr_en)
        begin
            case (cfg_ch.addr)
                lbmc_pkg::REG_STROBE_HALF:   cfg_reg.strobe_half_ms     <= cfg_ch.data;
                lbmc_pkg::REG_BEACON_HALF:   cfg_reg.beacon_half_ms     <= cfg_ch.data;
                lbmc_pkg::REG_PULSE:         cfg_reg.pulse_ms           <= cfg_ch.data;
                lbmc_pkg::REG_DEMO_ON:       cfg_reg.demo_on_ms         <= cfg_ch.data;
                lbmc_pkg::REG_DEMO_OFF:      cfg_reg.demo_off_ms        <= cfg_ch.data;
                lbmc_pkg::REG_DEMO_STROBE_N: cfg_reg.demo_strobe_cycles <= cfg_ch.data[7:0];
                lbmc_pkg::REG_DEMO_BEACON_N: cfg_reg.demo_beacon_cycles <= cfg_ch.data[7:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lbmc_core.sv
`default_nettype none

module lbmc_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic          op,
    input  wire logic [7:0]    cmd_byte,
    input  wire lbmc_pkg::cfg_t cfg,
    output lbmc_pkg::result_t  res
);

    lbmc_pkg::state_t state_reg;
    lbmc_pkg::state_t state_next;
    logic             unknown;

    logic [16:0] ph_inc;
    logic [16:0] pl_inc;
    logic [15:0] thr;
    logic        ph_done;
    logic        off_end;
    logic [7:0]  cyc_inc;
    logic [7:0]  cyc_limit;
    logic        cyc_done;

    function automatic lbmc_pkg::state_t restart_pat(lbmc_pkg::state_t s);
        lbmc_pkg::state_t r;
        r             = s;
        r.phase_timer = '0;
        r.half_phase  = 1'b0;
        r.demo_stage  = lbmc_pkg::STAGE_ON;
        r.cycle_count = '0;
        if (s.mode == lbmc_pkg::MODE_DEMO || s.mode == lbmc_pkg::MODE_STROBE
            || s.mode == lbmc_pkg::MODE_BEACON)
            r.laser = 1'b1;
        else if (s.mode == lbmc_pkg::MODE_OFF)
            r.laser = 1'b0;
        return r;
    endfunction

    function automatic lbmc_pkg::state_t enter_stage(lbmc_pkg::state_t s, logic [1:0] stg);
        lbmc_pkg::state_t r;
        r             = s;
        r.demo_stage  = stg;
        r.phase_timer = '0;
        r.half_phase  = 1'b0;
        r.cycle_count = '0;
        r.laser       = (stg != lbmc_pkg::STAGE_OFF);
        return r;
    endfunction

    // one shared timer compare: threshold follows mode and demo stage
    always_comb
    begin
        thr = state_reg.phase_timer;
        case (state_reg.mode)
            lbmc_pkg::MODE_STROBE: thr = cfg.strobe_half_ms;
            lbmc_pkg::MODE_BEACON: thr = cfg.beacon_half_ms;
            lbmc_pkg::MODE_DEMO:
            begin
                case (state_reg.demo_stage)
                    lbmc_pkg::STAGE_ON:     thr = cfg.demo_on_ms;
                    lbmc_pkg::STAGE_STROBE: thr = cfg.strobe_half_ms;
                    lbmc_pkg::STAGE_BEACON: thr = cfg.beacon_half_ms;
                    default:                thr = cfg.demo_off_ms;
                endcase
            end
            default: thr = cfg.strobe_half_ms;
        endcase
    end

    assign ph_inc    = {1'b0, state_reg.phase_timer} + 17'd1;
    assign pl_inc    = {1'b0, state_reg.pulse_timer} + 17'd1;
    assign ph_done   = (ph_inc >= {1'b0, thr});
    assign off_end   = ph_done && state_reg.half_phase;
    assign cyc_inc   = state_reg.cycle_count + 8'd1;
    assign cyc_limit = (state_reg.demo_stage == lbmc_pkg::STAGE_STROBE)
                       ? cfg.demo_strobe_cycles : cfg.demo_beacon_cycles;
    assign cyc_done  = (cyc_inc >= cyc_limit) || (cyc_inc == 8'd0);

    always_comb
    begin
        state_next = state_reg;
        unknown    = 1'b0;
        if (op == lbmc_pkg::OP_TICK)
        begin
            if (state_reg.pulse_busy)
            begin
                if (pl_inc >= {1'b0, cfg.pulse_ms})
                begin
                    state_next.pulse_busy  = 1'b0;
                    state_next.pulse_timer = '0;
                    state_next.laser       = 1'b0;
                    state_next             = restart_pat(state_next);
                end
                else
                begin
                    state_next.pulse_timer = pl_inc[15:0];
                end
            end
            else if (state_reg.mode == lbmc_pkg::MODE_STROBE
                     || state_reg.mode == lbmc_pkg::MODE_BEACON
                     || (state_reg.mode == lbmc_pkg::MODE_DEMO
                         && (state_reg.demo_stage == lbmc_pkg::STAGE_STROBE
                             || state_reg.demo_stage == lbmc_pkg::STAGE_BEACON)))
            begin
                // blink half period; laser shows the new half
                if (ph_done)
                begin
                    state_next.phase_timer = '0;
                    state_next.half_phase  = ~state_reg.half_phase;
                    state_next.laser       = state_reg.half_phase;
                end
                else
                begin
                    state_next.phase_timer = ph_inc[15:0];
                end
                if (state_reg.mode == lbmc_pkg::MODE_DEMO && off_end)
                begin
                    state_next.cycle_count = cyc_inc;
                    if (cyc_done)
                        state_next = enter_stage(state_next, state_reg.demo_stage + 2'd1);
                end
            end
            else if (state_reg.mode == lbmc_pkg::MODE_DEMO)
            begin
                // solid on or off stage of the demo
                state_next.laser       = (state_reg.demo_stage == lbmc_pkg::STAGE_ON);
                state_next.phase_timer = ph_inc[15:0];
                if (ph_done)
                    state_next = enter_stage(state_next, state_reg.demo_stage + 2'd1);
            end
        end
        else if (!state_reg.pulse_busy && cmd_byte != lbmc_pkg::CH_CR
                 && cmd_byte != lbmc_pkg::CH_LF)
        begin
            case (cmd_byte) inside
                lbmc_pkg::CH_ONE, lbmc_pkg::CH_O_LC, lbmc_pkg::CH_O_UC:
                begin
                    state_next.mode  = lbmc_pkg::MODE_ON;
                    state_next.laser = 1'b1;
                    state_next       = restart_pat(state_next);
                end
                lbmc_pkg::CH_ZERO, lbmc_pkg::CH_F_LC, lbmc_pkg::CH_F_UC:
                begin
                    state_next.mode = lbmc_pkg::MODE_OFF;
                    state_next      = restart_pat(state_next);
                end
                lbmc_pkg::CH_S_LC, lbmc_pkg::CH_S_UC:
                begin
                    state_next.mode = lbmc_pkg::MODE_STROBE;
                    state_next      = restart_pat(state_next);
                end
                lbmc_pkg::CH_B_LC, lbmc_pkg::CH_B_UC:
                begin
                    state_next.mode = lbmc_pkg::MODE_BEACON;
                    state_next      = restart_pat(state_next);
                end
                lbmc_pkg::CH_D_LC, lbmc_pkg::CH_D_UC:
                begin
                    state_next.mode = lbmc_pkg::MODE_DEMO;
                    state_next      = restart_pat(state_next);
                end
                lbmc_pkg::CH_H_LC, lbmc_pkg::CH_H_UC:
                begin
                    state_next = restart_pat(state_next);
                end
                lbmc_pkg::CH_P_LC, lbmc_pkg::CH_P_UC:
                begin
                    state_next             = restart_pat(state_next);
                    state_next.pulse_busy  = 1'b1;
                    state_next.pulse_timer = '0;
                    state_next.laser       = 1'b1;
                end
                default:
                begin
                    unknown = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= lbmc_pkg::MODE_DEMO;
            state_reg.laser       <= 1'b0;
            state_reg.phase_timer <= '0;
            state_reg.half_phase  <= 1'b0;
            state_reg.demo_stage  <= lbmc_pkg::STAGE_ON;
            state_reg.cycle_count <= '0;
            state_reg.pulse_busy  <= 1'b0;
            state_reg.pulse_timer <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    assign res.laser_on     = state_next.laser;
    assign res.mode         = 3'(state_next.mode);
    assign res.unknown_cmd  = unknown;
    assign res.pulse_active = state_next.pulse_busy;

endmodule

`default_nettype wire

FILE: rtl/lbmc_out_reg.sv
`default_nettype none

module lbmc_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire lbmc_pkg::result_t res,
    output logic               can_load,
    lbmc_out_if.source         out_ch
);

    logic              valid_reg;
    logic              valid_next;
    lbmc_pkg::result_t data_reg;

    // free slot, or the held result leaves in this cycle
    assign can_load = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.laser_on     = data_reg.laser_on;
    assign out_ch.mode         = data_reg.mode;
    assign out_ch.unknown_cmd  = data_reg.unknown_cmd;
    assign out_ch.pulse_active = data_reg.pulse_active;

endmodule

`default_nettype wire

FILE: rtl/laser_blink_mode_controller.sv
// A result is registered and appears on the output channel in the cycle after its item is transferred.
// Throughput: one item per cycle while the output is taken; the single output register refills in the cycle it drains.
// The mode, timer and pulse update is one combinational pass into the state registers.
// Reset: mode auto demo, laser off, all timers and counters cleared, registers to defaults.
`default_nettype none

module laser_blink_mode_controller (
    input  wire logic    clk,
    input  wire logic    rst_n,
    lbmc_in_if.sink      in_ch,
    lbmc_out_if.source   out_ch,
    lbmc_cfg_if.sink     cfg_ch
);

    lbmc_pkg::cfg_t    cfg;
    lbmc_pkg::result_t res;
    logic              can_load;
    logic              accept;

    assign in_ch.ready = can_load;
    assign accept      = in_ch.valid && can_load;

    lbmc_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    lbmc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .op       (in_ch.op),
        .cmd_byte (in_ch.cmd_byte),
        .cfg      (cfg),
        .res      (res)
    );

    lbmc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res      (res),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lbmc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    // no register sits at this index; writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;

    lbmc_in_if  in_if();
    lbmc_out_if out_if();
    lbmc_cfg_if cfg_if();

    laser_blink_mode_controller DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg_ch (cfg_if)
    );

    // predictor copy of the registers, at their reset values
    logic [15:0] strobe_half   = 16'd50;
    logic [15:0] beacon_half   = 16'd250;
    logic [15:0] pulse_len     = 16'd500;
    logic [15:0] demo_on_len   = 16'd2000;
    logic [15:0] demo_off_len  = 16'd1500;
    logic [7:0]  demo_strobe_n = 8'd15;
    logic [7:0]  demo_beacon_n = 8'd3;

    // predictor state
    mode_t       cur_mode    = MODE_DEMO;
    logic        laser_lvl   = 1'b0;
    int unsigned phase_cnt   = 0;
    logic        in_off_half = 1'b0;
    logic [1:0]  stage       = STAGE_ON;
    logic [7:0]  cycles_done = 8'd0;
    logic        pulse_on    = 1'b0;
    int unsigned pulse_cnt   = 0;

    result_t pending_results [$];
    int      error_count    = 0;
    int      sender_idle_pct = 0;
    int      recv_stall_pct  = 0;
    int      hold_request    = 0;
    int      cycle_total     = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_total++;
        if (cycle_total > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void pattern_restart();
        phase_cnt   = 0;
        in_off_half = 1'b0;
        stage       = STAGE_ON;
        cycles_done = 8'd0;
        if (cur_mode == MODE_DEMO || cur_mode == MODE_STROBE || cur_mode == MODE_BEACON)
            laser_lvl = 1'b1;
        else if (cur_mode == MODE_OFF)
            laser_lvl = 1'b0;
    endfunction

    // one tick of a blink pattern; true when an off half has just ended
    function automatic bit blink_advance(input int unsigned half_len);
        phase_cnt++;
        if (phase_cnt >= half_len)
        begin
            phase_cnt   = 0;
            in_off_half = !in_off_half;
            laser_lvl   = !in_off_half;
            return !in_off_half;
        end
        return 1'b0;
    endfunction

    function automatic void stage_enter(input logic [1:0] next_stage);
        stage       = next_stage;
        phase_cnt   = 0;
        in_off_half = 1'b0;
        cycles_done = 8'd0;
        laser_lvl   = (next_stage != STAGE_OFF);
    endfunction

    function automatic void demo_advance();
        case (stage)
            STAGE_ON:
            begin
                laser_lvl = 1'b1;
                phase_cnt++;
                if (phase_cnt >= demo_on_len)
                    stage_enter(STAGE_STROBE);
            end
            STAGE_STROBE:
                if (blink_advance(strobe_half))
                begin
                    cycles_done++;
                    if (cycles_done >= demo_strobe_n || cycles_done == 8'd0)
                        stage_enter(STAGE_BEACON);
                end
            STAGE_BEACON:
                if (blink_advance(beacon_half))
                begin
                    cycles_done++;
                    if (cycles_done >= demo_beacon_n || cycles_done == 8'd0)
                        stage_enter(STAGE_OFF);
                end
            default:
            begin
                laser_lvl = 1'b0;
                phase_cnt++;
                if (phase_cnt >= demo_off_len)
                    stage_enter(STAGE_ON);
            end
        endcase
    endfunction

    function automatic result_t predict_laser_step(input logic op, input logic [7:0] b);
        result_t res;
        logic    unrecognized = 1'b0;
        if (op == OP_TICK)
        begin
            if (pulse_on)
            begin
                pulse_cnt++;
                if (pulse_cnt >= pulse_len)
                begin
                    pulse_on  = 1'b0;
                    pulse_cnt = 0;
                    laser_lvl = 1'b0;
                    pattern_restart();
                end
            end
            else if (cur_mode == MODE_STROBE)
                void'(blink_advance(strobe_half));
            else if (cur_mode == MODE_BEACON)
                void'(blink_advance(beacon_half));
            else if (cur_mode == MODE_DEMO)
                demo_advance();
        end
        else if (!pulse_on && b != CH_CR && b != CH_LF)
        begin
            case (b)
                CH_ONE, CH_O_LC, CH_O_UC:
                begin
                    cur_mode  = MODE_ON;
                    laser_lvl = 1'b1;
                    pattern_restart();
                end
                CH_ZERO, CH_F_LC, CH_F_UC:
                begin
                    cur_mode = MODE_OFF;
                    pattern_restart();
                end
                CH_S_LC, CH_S_UC:
                begin
                    cur_mode = MODE_STROBE;
                    pattern_restart();
                end
                CH_B_LC, CH_B_UC:
                begin
                    cur_mode = MODE_BEACON;
                    pattern_restart();
                end
                CH_D_LC, CH_D_UC:
                begin
                    cur_mode = MODE_DEMO;
                    pattern_restart();
                end
                CH_H_LC, CH_H_UC:
                    pattern_restart();
                CH_P_LC, CH_P_UC:
                begin
                    pattern_restart();
                    pulse_on  = 1'b1;
                    pulse_cnt = 0;
                    laser_lvl = 1'b1;
                end
                default:
                    unrecognized = 1'b1;
            endcase
        end
        res.laser_on     = laser_lvl;
        res.mode         = cur_mode;
        res.unknown_cmd  = unrecognized;
        res.pulse_active = pulse_on;
        return res;
    endfunction

    // result side: random stalls, plus a long hold when a test asks for one
    initial
    begin : result_receiver
        int hold_left;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no prediction pending");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_if.laser_on !== want.laser_on)
                begin
                    $error("laser_on: expected %0d, actual %0d", want.laser_on, out_if.laser_on);
                    error_count++;
                end
                if (out_if.mode !== want.mode)
                begin
                    $error("mode: expected %0d, actual %0d", want.mode, out_if.mode);
                    error_count++;
                end
                if (out_if.unknown_cmd !== want.unknown_cmd)
                begin
                    $error("unknown_cmd: expected %0d, actual %0d",
                           want.unknown_cmd, out_if.unknown_cmd);
                    error_count++;
                end
                if (out_if.pulse_active !== want.pulse_active)
                begin
                    $error("pulse_active: expected %0d, actual %0d",
                           want.pulse_active, out_if.pulse_active);
                    error_count++;
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_if.valid    <= 1'b0;
            in_if.op       <= 1'($urandom);
            in_if.cmd_byte <= 8'($urandom);
            @(negedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.op       <= op;
        in_if.cmd_byte <= b;
        do @(posedge clk); while (!in_if.ready);
        pending_results.push_back(predict_laser_step(op, b));
        @(negedge clk);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_STROBE_HALF:   strobe_half   = value;
            REG_BEACON_HALF:   beacon_half   = value;
            REG_PULSE:         pulse_len     = value;
            REG_DEMO_ON:       demo_on_len   = value;
            REG_DEMO_OFF:      demo_off_len  = value;
            REG_DEMO_STROBE_N: demo_strobe_n = value[7:0];
            REG_DEMO_BEACON_N: demo_beacon_n = value[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // only call with the block idle
    task automatic apply_config(input logic [15:0] s_half, b_half, p_len, on_len, off_len,
                                input logic [7:0] s_n, b_n, input bit with_unused);
        write_reg(REG_STROBE_HALF, s_half);
        write_reg(REG_BEACON_HALF, b_half);
        write_reg(REG_PULSE, p_len);
        write_reg(REG_DEMO_ON, on_len);
        write_reg(REG_DEMO_OFF, off_len);
        // upper data bits are don't-care for the 8-bit counts
        write_reg(REG_DEMO_STROBE_N, {8'($urandom), s_n});
        write_reg(REG_DEMO_BEACON_N, {8'($urandom), b_n});
        if (with_unused)
            write_reg(REG_UNUSED, 16'($urandom));
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 19))
            0:  return CH_ONE;
            1:  return CH_O_LC;
            2:  return CH_O_UC;
            3:  return CH_ZERO;
            4:  return CH_F_LC;
            5:  return CH_F_UC;
            6:  return CH_S_LC;
            7:  return CH_S_UC;
            8:  return CH_B_LC;
            9:  return CH_B_UC;
            10: return CH_P_LC;
            11: return CH_P_UC;
            12: return CH_D_LC;
            13: return CH_D_UC;
            14: return CH_H_LC;
            15: return CH_H_UC;
            16: return CH_CR;
            17: return CH_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 16'd0;
        if (r < 14)
            return 16'($urandom_range(7, 60));
        return 16'($urandom_range(1, 6));
    endfunction

    function automatic logic [7:0] pick_count();
        if ($urandom_range(0, 9) == 0)
            return 8'd0;
        return 8'($urandom_range(1, 4));
    endfunction

    // mostly ticks so patterns advance, some commands, a little raw noise
    task automatic random_items(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_item(OP_TICK, 8'($urandom));
            else if (r < 92)
                send_item(OP_CMD, pick_command());
            else
                send_item(OP_CMD, 8'($urandom));
        end
    endtask

    task automatic random_config();
        apply_config(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                     pick_count(), pick_count(), 1'b0);
    endtask

    task automatic test_commands();
        logic [7:0] script [] = '{CH_ONE, CH_O_LC, CH_O_UC, CH_ZERO, CH_F_LC, CH_F_UC,
                                  CH_S_LC, CH_S_UC, CH_B_LC, CH_B_UC, CH_D_LC, CH_D_UC,
                                  CH_H_LC, CH_H_UC, CH_CR, CH_LF, 8'h00, 8'hff,
                                  CH_P_LC, CH_O_UC, 8'h00, CH_P_UC};
        send_item(OP_TICK, 8'hff);
        // the last three land inside the pulse and must be dropped
        foreach (script[i])
            send_item(OP_CMD, script[i]);
        send_item(OP_TICK, 8'h00);
        settle();
    endtask

    task automatic test_short_periods();
        apply_config(16'd1, 16'd2, 16'd3, 16'd2, 16'd1, 8'd1, 8'd2, 1'b0);
        // pulse from solid on leaves the laser dark when it ends
        send_item(OP_CMD, CH_O_UC);
        send_item(OP_CMD, CH_P_LC);
        repeat (4) send_item(OP_TICK, 8'($urandom));
        send_item(OP_CMD, CH_D_LC);
        repeat (30) send_item(OP_TICK, 8'($urandom));
        send_item(OP_CMD, CH_S_UC);
        repeat (6) send_item(OP_TICK, 8'($urandom));
        send_item(OP_CMD, CH_B_LC);
        repeat (8) send_item(OP_TICK, 8'($urandom));
        random_items(60);
        settle();
    endtask

    task automatic test_register_zero();
        // zero lengths and counts behave as one
        apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b1);
        send_item(OP_CMD, CH_D_UC);
        repeat (20) send_item(OP_TICK, 8'($urandom));
        send_item(OP_CMD, CH_P_UC);
        send_item(OP_TICK, 8'($urandom));
        random_items(80);
        settle();
    endtask

    task automatic test_register_max();
        apply_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 1'b0);
        send_item(OP_CMD, CH_D_LC);
        random_items(60);
        settle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            random_config();
            random_items(350);
            settle();
        end
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
    endtask

    task automatic test_backpressure();
        random_config();
        // output held off long enough that the input side has to stall
        hold_request = 300;
        random_items(120);
        settle();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_if.valid    = 1'b0;
        in_if.op       = OP_TICK;
        in_if.cmd_byte = 8'd0;
        cfg_if.valid   = 1'b0;
        cfg_if.addr    = REG_STROBE_HALF;
        cfg_if.data    = 16'd0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_commands();
        test_short_periods();
        test_register_zero();
        test_register_max();
        test_random_phases();
        test_backpressure();

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
